// ===== sv/marker_toggled_comment_filter_defines.svh =====
// Assertion macros for the comment filter RTL.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef MARKER_TOGGLED_COMMENT_FILTER_DEFINES_SVH
`define MARKER_TOGGLED_COMMENT_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define MCTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCTF_ASSERT(lbl, prop, msg)
`define MCTF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/mctf_pkg.sv =====
// Shared constants, codes and control types of the comment filter.
// No dependencies; used by the interfaces' users, controller, datapath and top.
`default_nettype none
package mctf_pkg;

  localparam int KEY_LEN = 11;
  localparam int COL_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_BANG    = 8'h21;
  localparam logic [7:0] BYTE_PLUS    = 8'h2B;
  localparam logic [7:0] BYTE_MINUS   = 8'h2D;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;

  // head buffer after reset: "01234567890"
  localparam logic [7:0] HEAD_RESET [KEY_LEN] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
  };

  localparam logic [1:0] MODE_STRIP = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_COPY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAG_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SECOND = 1'b1;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_BANG  = 2'd1;
  localparam logic [1:0] SRC_HEAD  = 2'd2;

  typedef struct packed {
    logic             store;       // write byte into head, advance column
    logic             line_end;    // key compare, mode toggle, column clear
    logic             set_la;
    logic             clr_la;
    logic             emit;        // load output register
    logic [1:0]       emit_src;
    logic             emit_last;
    logic             flush_load;
    logic [COL_W-1:0] flush_start;
    logic [COL_W-1:0] flush_end;
    logic             flush_adv;
  } ctl_cmd_t;

  typedef struct packed {
    logic             is_eos;
    logic             is_newline;
    logic             is_bang;
    logic             la;
    logic [1:0]       mode;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_next;    // column after a store
    logic             plus_next;   // head after a store equals plus key
    logic             ptr_last;
    logic             out_free;
  } ctl_status_t;

  // byte idx of the marker key built from sym and the two tag bytes
  function automatic logic [7:0] key_byte(input logic [COL_W-1:0] idx,
                                          input logic [7:0] sym,
                                          input logic [7:0] t1,
                                          input logic [7:0] t2);
    logic [7:0] k;
    case (idx)
      4'd0:    k = BYTE_BANG;
      4'd4:    k = BYTE_SPACE;
      4'd5:    k = t1;
      4'd6:    k = t2;
      4'd7:    k = BYTE_SPACE;
      default: k = sym;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mctf_in_if.sv =====
// Input channel of the comment filter: valid/ready with text byte and end flag.
// Standalone; no package dependency.
`default_nettype none
interface mctf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_stream;
  modport source(output valid, output text_byte, output end_of_stream, input ready);
  modport sink(input valid, input text_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== sv/mctf_out_if.sv =====
// Output channel of the comment filter: valid/ready with result byte and run end.
// Standalone; no package dependency.
`default_nettype none
interface mctf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/marker_toggled_comment_filter.sv =====
// Top level of the marker-toggled comment filter: controller plus datapath.
// Depends on mctf_pkg, mctf_in_if, mctf_out_if, mctf_ctrl and mctf_datapath.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   text_byte[7:0], end_of_stream
//   out_ch    out  valid/ready   out_byte[7:0], last_of_run
//   cfg       in   cfg_write     cfg_index (0 tag_first, 1 tag_second), cfg_data[7:0]
//
// Plain bytes are emitted as accepted; input is ready while the output register is empty or
// its item is taken in the same cycle. A bang added at line start is emitted first and holds
// input until the stored byte follows; a strip lookahead drain holds input while its drained
// bytes (up to 11) leave the head, each paced by the single output register.
// Reset (synchronous) sets copy mode, tags 0 and head "01234567890"; no clearing pass.
`default_nettype none
module marker_toggled_comment_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mctf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  mctf_in_if.sink                        in_ch,
  mctf_out_if.source                     out_ch
);
  import mctf_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  mctf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mctf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (in_ch.text_byte),
    .in_eos    (in_ch.end_of_stream),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run)
  );

endmodule
`default_nettype wire

// ===== sv/mctf_datapath.sv =====
// Datapath: head buffer, column, mode, lookahead flag, tags, flush pointer, output register.
// Depends on mctf_pkg; driven by commands from mctf_ctrl.
`default_nettype none
module mctf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mctf_pkg::ctl_cmd_t            cmd,
  output mctf_pkg::ctl_status_t         status,
  input  logic [7:0]                    in_byte,
  input  logic                          in_eos,
  input  logic                          cfg_write,
  input  logic [mctf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);
  import mctf_pkg::*;

  logic [7:0]       head [KEY_LEN];
  logic [7:0]       head_wr [KEY_LEN];
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_inc;
  logic [1:0]       mode;
  logic [1:0]       mode_next;
  logic             la;
  logic [7:0]       tag_first;
  logic [7:0]       tag_second;
  logic [COL_W-1:0] ptr;
  logic [COL_W-1:0] flush_end;
  logic             col_room;
  logic             plus_hit;
  logic             minus_hit;

  assign col_room = (col < COL_W'(KEY_LEN));
  assign col_inc  = col_room ? COL_W'(col + 1'b1) : col;

  // head as it stands after the byte of this item is stored
  always_comb begin
    plus_hit  = 1'b1;
    minus_hit = 1'b1;
    for (int i = 0; i < KEY_LEN; i++) begin
      head_wr[i] = (col_room && col == COL_W'(i)) ? in_byte : head[i];
      if (head_wr[i] != key_byte(COL_W'(i), BYTE_PLUS, tag_first, tag_second))
        plus_hit = 1'b0;
      if (head_wr[i] != key_byte(COL_W'(i), BYTE_MINUS, tag_first, tag_second))
        minus_hit = 1'b0;
    end
  end

  always_comb begin
    mode_next = mode;
    if (plus_hit) begin
      if (mode_next == MODE_COPY) mode_next = MODE_STRIP;
      else if (mode_next == MODE_STRIP) mode_next = MODE_COPY;
    end
    if (minus_hit) begin
      if (mode_next == MODE_COPY) mode_next = MODE_ADD;
      else if (mode_next == MODE_ADD) mode_next = MODE_COPY;
    end
  end

  always_comb begin
    status.is_eos     = in_eos;
    status.is_newline = (in_byte == BYTE_NEWLINE);
    status.is_bang    = (in_byte == BYTE_BANG);
    status.la         = la;
    status.mode       = mode;
    status.col        = col;
    status.col_next   = col_inc;
    status.plus_next  = plus_hit;
    status.ptr_last   = (ptr == COL_W'(flush_end - 1'b1));
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_LEN; i++) head[i] <= HEAD_RESET[i];
      col        <= '0;
      mode       <= MODE_COPY;
      la         <= 1'b0;
      tag_first  <= '0;
      tag_second <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.store) begin
        for (int i = 0; i < KEY_LEN; i++) head[i] <= head_wr[i];
        col <= col_inc;
      end
      if (cmd.line_end) begin
        col  <= '0;
        mode <= mode_next;
      end
      if (cmd.set_la) la <= 1'b1;
      else if (cmd.clr_la) la <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CFG_TAG_FIRST:  tag_first  <= cfg_data;
          CFG_TAG_SECOND: tag_second <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload: flush pointer and output register
  always_ff @(posedge clk) begin
    if (cmd.flush_load) begin
      ptr       <= cmd.flush_start;
      flush_end <= cmd.flush_end;
    end else if (cmd.flush_adv) begin
      ptr <= COL_W'(ptr + 1'b1);
    end
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_src)
        SRC_BANG: out_byte <= BYTE_BANG;
        SRC_HEAD: out_byte <= head[ptr];
        default:  out_byte <= in_byte;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/mctf_ctrl.sv =====
// Controller: decides per item what the datapath stores, emits and drains.
// Depends on mctf_pkg and the assertion macros header.
`default_nettype none
`include "marker_toggled_comment_filter_defines.svh"
module mctf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mctf_pkg::ctl_status_t status,
  output mctf_pkg::ctl_cmd_t    cmd
);
  import mctf_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic state;
  logic state_next;
  logic acc;

  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.emit_src = SRC_INPUT;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (status.is_eos) begin
            if (status.la) begin
              cmd.clr_la = 1'b1;
              // drain bytes after the dropped bang, if any
              if (status.col > COL_W'(1)) begin
                cmd.flush_load  = 1'b1;
                cmd.flush_start = COL_W'(1);
                cmd.flush_end   = status.col;
                state_next      = ST_FLUSH;
              end
            end
          end else if (status.la) begin
            cmd.store = 1'b1;
            if (status.col_next == COL_W'(KEY_LEN) || status.is_newline) begin
              cmd.clr_la     = 1'b1;
              cmd.flush_load = 1'b1;
              cmd.flush_end  = status.col_next;
              cmd.flush_start =
                (status.col_next == COL_W'(KEY_LEN) && status.plus_next) ? '0 : COL_W'(1);
              cmd.line_end   = status.is_newline;
              state_next     = ST_FLUSH;
            end
          end else begin
            cmd.store    = 1'b1;
            cmd.line_end = status.is_newline;
            case (status.mode)
              MODE_STRIP: begin
                if (status.is_bang && status.col_next == COL_W'(1)) begin
                  cmd.set_la = 1'b1;
                end else begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                end
              end
              MODE_ADD: begin
                cmd.emit = 1'b1;
                if (!status.is_bang && status.col_next == COL_W'(1)) begin
                  // bang first, then the stored first byte from head
                  cmd.emit_src    = SRC_BANG;
                  cmd.flush_load  = 1'b1;
                  cmd.flush_start = '0;
                  cmd.flush_end   = COL_W'(1);
                  state_next      = ST_FLUSH;
                end else begin
                  cmd.emit_last = 1'b1;
                end
              end
              default: begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
              end
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = SRC_HEAD;
          cmd.emit_last = status.ptr_last;
          cmd.flush_adv = 1'b1;
          if (status.ptr_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MCTF_ASSERT(a_emit_slot_free, cmd.emit |-> status.out_free, "emit into a full output register")
  `MCTF_ASSERT(a_flush_no_store, (state == ST_FLUSH) |-> !(cmd.store || cmd.line_end), "head changed during drain")
  `MCTF_ASSERT(a_col_bound, status.col <= COL_W'(KEY_LEN), "column past head length")
  `MCTF_ASSERT(a_la_after_set, cmd.set_la |=> status.la && status.col == COL_W'(1), "lookahead not started on first column")

endmodule
`default_nettype wire
